// ===== hw/rtl/rcspf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcspf_pkg: shared types and constants
// Channel slots, configuration indexes and the event, config and frame structs
// that the RC servo pulse frame capture modules pass between them.
// ----------------------------------------------------------------------------
package rcspf_pkg;

  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned US_W      = 15;

  localparam logic [2:0] SLOT_AUX2     = 3'd0;
  localparam logic [2:0] SLOT_STEERING = 3'd1;
  localparam logic [2:0] SLOT_THROTTLE = 3'd2;
  localparam logic [2:0] SLOT_AUX      = 3'd3;
  localparam logic [2:0] SLOT_AUX3     = 3'd4;

  localparam logic [1:0] INPUT_SHARED = 2'd0;

  localparam logic [US_W-1:0] LOCAL_SWITCH_US = 15'd1500;

  localparam logic [1:0] CFG_COUNTER_TOP  = 2'd0;
  localparam logic [1:0] CFG_SHARED_EN    = 2'd1;
  localparam logic [1:0] CFG_AUX_LOCAL_SW = 2'd2;

  typedef struct packed {
    logic [1:0]        capture_input;
    logic              rising_edge;
    logic              aux3_selected;
    logic [TIME_W-1:0] capture_time;
  } event_t;

  typedef struct packed {
    logic [TIME_W-1:0] counter_top;
    logic              shared_input_enable;
    logic              aux_is_local_switch;
  } cfg_t;

  typedef struct packed {
    logic [US_W-1:0] steering_us;
    logic [US_W-1:0] throttle_us;
    logic [US_W-1:0] aux_us;
    logic [US_W-1:0] aux2_us;
    logic [US_W-1:0] aux3_us;
  } frame_t;

endpackage

// ===== hw/rtl/rcspf_chan_state.sv =====
// ----------------------------------------------------------------------------
// rcspf_chan_state: per-channel capture state and frame assembly
// Holds start times, widths and seen flags; updates them for one event per
// cycle and flags when the event closes a frame.
// ----------------------------------------------------------------------------
module rcspf_chan_state (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  ev_valid,
  input  rcspf_pkg::event_t     ev,
  input  rcspf_pkg::cfg_t       cfg,
  output logic                  frame_valid,
  output rcspf_pkg::frame_t     frame
);

  logic [rcspf_pkg::TIME_W-1:0]    start_times_r [rcspf_pkg::NUM_SLOTS];
  logic [rcspf_pkg::TIME_W-1:0]    pulse_widths_r[rcspf_pkg::NUM_SLOTS];
  logic [rcspf_pkg::NUM_SLOTS-1:0] seen_r, seen_nxt;

  logic [2:0]                      slot;
  logic [rcspf_pkg::NUM_SLOTS-1:0] bit_sel;
  logic                            active;
  logic [rcspf_pkg::TIME_W-1:0]    start_t;
  logic [rcspf_pkg::TIME_W-1:0]    period_add;
  logic [rcspf_pkg::TIME_W-1:0]    width;

  always_comb begin
    if (ev.capture_input == rcspf_pkg::INPUT_SHARED) begin
      slot = ev.aux3_selected ? rcspf_pkg::SLOT_AUX3 : rcspf_pkg::SLOT_AUX2;
    end else begin
      slot = {1'b0, ev.capture_input};
    end
    active  = ev_valid &&
              ((ev.capture_input != rcspf_pkg::INPUT_SHARED) || cfg.shared_input_enable);
    bit_sel = rcspf_pkg::NUM_SLOTS'(1) << slot;
    start_t = start_times_r[slot];
    // wrapped counter: add the period (top + 1), all modulo 2^16
    period_add = (start_t > ev.capture_time) ? (cfg.counter_top + 16'd1) : '0;
    width      = ev.capture_time - start_t + period_add;
  end

  assign frame_valid = active && ev.rising_edge && ((seen_r & bit_sel) != '0);

  always_comb begin
    seen_nxt = seen_r;
    if (active && ev.rising_edge) begin
      seen_nxt = frame_valid ? bit_sel : (seen_r | bit_sel);
    end
  end

  always_comb begin
    frame.steering_us = pulse_widths_r[rcspf_pkg::SLOT_STEERING][15:1];
    frame.throttle_us = pulse_widths_r[rcspf_pkg::SLOT_THROTTLE][15:1];
    frame.aux_us      = cfg.aux_is_local_switch ? rcspf_pkg::LOCAL_SWITCH_US
                                                : pulse_widths_r[rcspf_pkg::SLOT_AUX][15:1];
    frame.aux2_us     = pulse_widths_r[rcspf_pkg::SLOT_AUX2][15:1];
    frame.aux3_us     = pulse_widths_r[rcspf_pkg::SLOT_AUX3][15:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      for (int i = 0; i < rcspf_pkg::NUM_SLOTS; i++) begin
        start_times_r[i]  <= '0;
        pulse_widths_r[i] <= '0;
      end
    end else begin
      seen_r <= seen_nxt;
      if (active) begin
        if (ev.rising_edge) begin
          start_times_r[slot] <= ev.capture_time;
        end else begin
          pulse_widths_r[slot] <= width;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rcspf_out_reg.sv =====
// ----------------------------------------------------------------------------
// rcspf_out_reg: result register
// Holds one frame until the receiver takes it.
// ----------------------------------------------------------------------------
module rcspf_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  rcspf_pkg::frame_t frame_in,
  input  logic              out_stall,
  output logic              out_valid,
  output rcspf_pkg::frame_t frame_out
);

  logic              valid_r, valid_nxt;
  rcspf_pkg::frame_t frame_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_in;
    end
  end

  assign out_valid = valid_r;
  assign frame_out = frame_r;

endmodule

// ===== hw/rtl/rc_servo_pulse_frame_capture_top.sv =====
// ----------------------------------------------------------------------------
// rc_servo_pulse_frame_capture_top: RC servo pulse frame capture
// Turns timestamped capture edges into frames of five servo pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one edge event per transaction: capture input index,
//   edge kind, aux3 routing bit for the shared input, and the counter time.
//   Output channel (out_*): one frame transaction of five widths in us, sent
//   when a rising edge arrives on a channel already seen in this frame.
//   Config port (cfg_*): write-only; index 0 counter_top, 1 shared input
//   enable, 2 aux local switch. Write only while the block is idle.
// Flow: an event is registered at the input and processed once it can
//   advance; an event that closes a frame loads it into the output
//   register, which drives out_valid.
// Throughput: one event per cycle unless out_stall holds a waiting frame.
// Reset: synchronous, active low; clears start times, widths and seen flags,
//   and loads counter_top = 65535 with both switches off.
// Stall: while a frame waits in the output register under out_stall, the
//   input register holds its event and in_stall rises once it is full.
// ----------------------------------------------------------------------------
module rc_servo_pulse_frame_capture_top (
  input  logic        clk,
  input  logic        rst_n,
  // event input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_capture_input,
  input  logic        in_rising_edge,
  input  logic        in_aux3_selected,
  input  logic [15:0] in_capture_time,
  // frame output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_steering_us,
  output logic [14:0] out_throttle_us,
  output logic [14:0] out_aux_us,
  output logic [14:0] out_aux2_us,
  output logic [14:0] out_aux3_us,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  rcspf_pkg::cfg_t   cfg_r;
  rcspf_pkg::event_t s1_ev_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic              in_accept;
  logic              advance;
  logic              core_frame_valid;
  rcspf_pkg::frame_t core_frame;
  rcspf_pkg::frame_t out_frame;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counter_top         <= 16'hFFFF;
      cfg_r.shared_input_enable <= 1'b0;
      cfg_r.aux_is_local_switch <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcspf_pkg::CFG_COUNTER_TOP:  cfg_r.counter_top         <= cfg_wdata;
        rcspf_pkg::CFG_SHARED_EN:    cfg_r.shared_input_enable <= cfg_wdata[0];
        rcspf_pkg::CFG_AUX_LOCAL_SW: cfg_r.aux_is_local_switch <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // event moves on unless a frame is stuck in the output register
  assign advance   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ev_r.capture_input <= in_capture_input;
      s1_ev_r.rising_edge   <= in_rising_edge;
      s1_ev_r.aux3_selected <= in_aux3_selected;
      s1_ev_r.capture_time  <= in_capture_time;
    end
  end

  rcspf_chan_state u_chan_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_valid    (advance),
    .ev          (s1_ev_r),
    .cfg         (cfg_r),
    .frame_valid (core_frame_valid),
    .frame       (core_frame)
  );

  rcspf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (core_frame_valid),
    .frame_in  (core_frame),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .frame_out (out_frame)
  );

  assign out_steering_us = out_frame.steering_us;
  assign out_throttle_us = out_frame.throttle_us;
  assign out_aux_us      = out_frame.aux_us;
  assign out_aux2_us     = out_frame.aux2_us;
  assign out_aux3_us     = out_frame.aux3_us;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall raised with empty input register");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted transaction not held in input register");

  a_frame_from_rising: assert property (@(posedge clk) disable iff (!rst_n)
    core_frame_valid |-> (advance && s1_ev_r.rising_edge))
    else $error("frame produced without a rising edge event");

endmodule

// ===== test/rc_servo_pulse_frame_capture_top_tb.sv =====
// ----------------------------------------------------------------------------
// rc_servo_pulse_frame_capture_top_tb: self-checking bench for the capture top
// Drives edge transactions with random gaps against a randomly stalled frame
// receiver. A capture model predicts the frames of untyped rows; the monitor
// compares each output transaction, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module rc_servo_pulse_frame_capture_top_tb;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_capture_input;
  logic        in_rising_edge;
  logic        in_aux3_selected;
  logic [15:0] in_capture_time;
  logic        out_valid;
  logic        out_stall;
  logic [14:0] out_steering_us;
  logic [14:0] out_throttle_us;
  logic [14:0] out_aux_us;
  logic [14:0] out_aux2_us;
  logic [14:0] out_aux3_us;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  rc_servo_pulse_frame_capture_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_capture_input (in_capture_input),
    .in_rising_edge   (in_rising_edge),
    .in_aux3_selected (in_aux3_selected),
    .in_capture_time  (in_capture_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_steering_us  (out_steering_us),
    .out_throttle_us  (out_throttle_us),
    .out_aux_us       (out_aux_us),
    .out_aux2_us      (out_aux2_us),
    .out_aux3_us      (out_aux3_us),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Period of 2; the generous limit below is far beyond the slowest legal run.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("[rc_servo_pulse_frame_capture_top] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Capture model: its own copy of the registers and of the channel state
  // --------------------------------------------------------------------------
  logic [15:0] top_tick;
  bit          shared_en;
  bit          local_sw;
  logic [15:0] start_tick [rcspf_pkg::NUM_SLOTS];
  logic [15:0] width_tick [rcspf_pkg::NUM_SLOTS];
  logic [4:0]  seen_mask;

  rcspf_pkg::frame_t frames_due [$];  // frames predicted and not yet seen at the output
  int                errors;

  bit idle_on;        // 0 gives back-to-back traffic on both sides
  bit long_hold_req;  // asks the receiver for one long hold-off
  int hold_left;      // receiver stall cycles still to go

  // Applies one accepted edge to the model; returns 1 with the frame it emits.
  function automatic bit capture_edge(input logic [1:0] inp, input bit rise,
                                      input bit a3, input logic [15:0] t,
                                      output rcspf_pkg::frame_t fr);
    logic [2:0]  slot;
    logic [16:0] stop_tick;
    fr = '0;
    if (inp == rcspf_pkg::INPUT_SHARED) begin
      if (!shared_en) return 1'b0;
      slot = a3 ? rcspf_pkg::SLOT_AUX3 : rcspf_pkg::SLOT_AUX2;
    end else begin
      slot = {1'b0, inp};
    end
    if (!rise) begin
      // counter wrapped between the edges: add one full period
      stop_tick = {1'b0, t};
      if (start_tick[slot] > t) stop_tick = stop_tick + {1'b0, top_tick} + 17'd1;
      width_tick[slot] = 16'(stop_tick - {1'b0, start_tick[slot]});
      return 1'b0;
    end
    start_tick[slot] = t;
    if (seen_mask[slot]) begin
      fr.steering_us = width_tick[rcspf_pkg::SLOT_STEERING][15:1];
      fr.throttle_us = width_tick[rcspf_pkg::SLOT_THROTTLE][15:1];
      fr.aux_us      = local_sw ? rcspf_pkg::LOCAL_SWITCH_US
                                : width_tick[rcspf_pkg::SLOT_AUX][15:1];
      fr.aux2_us     = width_tick[rcspf_pkg::SLOT_AUX2][15:1];
      fr.aux3_us     = width_tick[rcspf_pkg::SLOT_AUX3][15:1];
      seen_mask       = '0;
      seen_mask[slot] = 1'b1;
      return 1'b1;
    end
    seen_mask[slot] = 1'b1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [14:0] got,
                             input logic [14:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Sender: one edge transaction, with a random gap in front of it
  // --------------------------------------------------------------------------
  task automatic send_capture(input logic [1:0] inp, input bit rise, input bit a3,
                              input logic [15:0] t, input bit typed,
                              input rcspf_pkg::frame_t want);
    int                gap;
    bit                has_frame;
    rcspf_pkg::frame_t fr;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_capture_input <= inp;
    in_rising_edge   <= rise;
    in_aux3_selected <= a3;
    in_capture_time  <= t;
    do @(posedge clk); while (in_stall);
    has_frame = capture_edge(inp, rise, a3, t, fr);
    // a typed row carries its own expected frame; the model only tracks state
    if (typed) frames_due.push_back(want);
    else if (has_frame) frames_due.push_back(fr);
  endtask

  // Quiet the input and let every due frame, plus the pipeline, drain out.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rcspf_pkg::CFG_COUNTER_TOP:  top_tick  = val;
      rcspf_pkg::CFG_SHARED_EN:    shared_en = val[0];
      rcspf_pkg::CFG_AUX_LOCAL_SW: local_sw  = val[0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall countdown at the falling edge, check at the rising edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= (hold_left != 0);
    if (hold_left != 0) hold_left--;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        report_mismatch("frame with none due");
      end else begin
        check_field("steering_us", out_steering_us, frames_due[0].steering_us);
        check_field("throttle_us", out_throttle_us, frames_due[0].throttle_us);
        check_field("aux_us",      out_aux_us,      frames_due[0].aux_us);
        check_field("aux2_us",     out_aux2_us,     frames_due[0].aux2_us);
        check_field("aux3_us",     out_aux3_us,     frames_due[0].aux3_us);
        void'(frames_due.pop_front());
      end
      // next stall is drawn per frame; a long one backs the block up
      hold_left = idle_on ? $urandom_range(0, 7) : 0;
      if (long_hold_req) begin
        hold_left     = 64;
        long_hold_req = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef enum bit { ROW_EDGE, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [1:0]        inp;    // capture input, or register index for ROW_REG
    bit                rise;
    bit                a3;
    logic [15:0]       val;    // capture time, or register data for ROW_REG
    bit                typed;
    rcspf_pkg::frame_t want;
  } row_t;

  function automatic row_t ev(input logic [1:0] inp, input bit rise, input bit a3,
                              input logic [15:0] t);
    ev = '{ROW_EDGE, inp, rise, a3, t, 1'b0, '0};
  endfunction

  function automatic row_t ev_frame(input logic [1:0] inp, input logic [15:0] t,
                                    input rcspf_pkg::frame_t want);
    ev_frame = '{ROW_EDGE, inp, 1'b1, 1'b0, t, 1'b1, want};
  endfunction

  function automatic row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
    reg_row = '{ROW_REG, idx, 1'b0, 1'b0, val, 1'b0, '0};
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t              dir_rows [];
    rcspf_pkg::frame_t reset_frame;
    logic [15:0]       wave_tick;
    logic [15:0]       width;
    logic [15:0]       top_pick;
    logic [1:0]        chan;
    bit                sel;
    int                sent;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_capture_input = '0;
    in_rising_edge   = 1'b0;
    in_aux3_selected = 1'b0;
    in_capture_time  = '0;
    out_stall        = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    errors           = 0;
    idle_on          = 1'b1;
    long_hold_req    = 1'b0;
    hold_left        = 0;
    top_tick         = 16'hFFFF;
    shared_en        = 1'b0;
    local_sw         = 1'b0;
    seen_mask        = '0;
    for (int i = 0; i < rcspf_pkg::NUM_SLOTS; i++) begin
      start_tick[i] = '0;
      width_tick[i] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset: steering 1 tick, throttle 0xFFFF ticks, aux 2468 ticks.
    reset_frame = '{15'd0, 15'd32767, 15'd1234, 15'd0, 15'd0};
    dir_rows = '{
      ev(rcspf_pkg::INPUT_SHARED, 1'b1, 1'b0, 16'h1234),  // shared input off: dropped
      ev(2'd1, 1'b0, 1'b0, 16'd100),           // falling with no rising first
      ev(2'd1, 1'b1, 1'b0, 16'hFFFF),
      ev(2'd1, 1'b0, 1'b0, 16'h0000),          // wrap at the top of the count
      ev(2'd2, 1'b1, 1'b0, 16'd1),
      ev(2'd2, 1'b0, 1'b0, 16'd1),             // equal times: zero width
      ev(2'd2, 1'b0, 1'b0, 16'd0),             // second falling, widest pulse
      ev(2'd3, 1'b1, 1'b0, 16'd2000),
      ev(2'd3, 1'b0, 1'b0, 16'd4468),
      ev_frame(2'd1, 16'd10, reset_frame),     // steering seen again: frame
      ev_frame(2'd1, 16'd20, reset_frame),     // repeated rising: frame again
      reg_row(rcspf_pkg::CFG_SHARED_EN, 16'd1),
      reg_row(rcspf_pkg::CFG_AUX_LOCAL_SW, 16'd1),
      reg_row(rcspf_pkg::CFG_COUNTER_TOP, 16'd0),
      ev(rcspf_pkg::INPUT_SHARED, 1'b1, 1'b0, 16'hFFFF),
      ev(rcspf_pkg::INPUT_SHARED, 1'b0, 1'b0, 16'h0001),  // wrap with a period of one
      ev(rcspf_pkg::INPUT_SHARED, 1'b1, 1'b1, 16'd100),
      ev(rcspf_pkg::INPUT_SHARED, 1'b0, 1'b1, 16'hFFFF),
      ev(2'd3, 1'b0, 1'b0, 16'h0000),
      ev(2'd1, 1'b1, 1'b0, 16'd555),
      ev(rcspf_pkg::INPUT_SHARED, 1'b1, 1'b1, 16'h8000),
      ev(rcspf_pkg::INPUT_SHARED, 1'b1, 1'b1, 16'h8001)
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(dir_rows[i].inp, dir_rows[i].val);
      end else begin
        send_capture(dir_rows[i].inp, dir_rows[i].rise, dir_rows[i].a3,
                     dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: mostly rising/falling pairs per channel on a running
    // counter, with a share of fully random transactions as noise.
    wave_tick = '0;
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0:       top_pick = 16'hFFFF;
        1:       top_pick = 16'h0000;
        3:       top_pick = 16'd39999;
        default: top_pick = 16'($urandom);
      endcase
      write_reg(rcspf_pkg::CFG_COUNTER_TOP, top_pick);
      write_reg(rcspf_pkg::CFG_SHARED_EN,
                (p == 2) ? 16'd0 : 16'($urandom_range(0, 1)) | 16'(p < 2));
      write_reg(rcspf_pkg::CFG_AUX_LOCAL_SW, (p == 1 || p == 3) ? 16'd1 : 16'd0);
      idle_on       = (p != 2);
      long_hold_req = (p == 0 || p == 3);
      sent = 0;
      while (sent < 250) begin
        if ($urandom_range(0, 4) == 0) begin
          chan = 2'($urandom_range(0, 3));
          send_capture(chan, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       16'($urandom), 1'b0, '0);
          sent++;
        end else begin
          chan      = 2'($urandom_range(0, 3));
          sel       = 1'($urandom_range(0, 1));
          wave_tick = wave_tick + 16'($urandom_range(50, 3000));
          width     = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(1800, 4200));
          send_capture(chan, 1'b1, sel, wave_tick, 1'b0, '0);
          send_capture(chan, 1'b0, sel, wave_tick + width, 1'b0, '0);
          wave_tick = wave_tick + width;
          sent += 2;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("[rc_servo_pulse_frame_capture_top] OK");
    else
      $display("[rc_servo_pulse_frame_capture_top] ERROR");
    $finish;
  end

endmodule
